// File: hdl/vbp_pkg.sv
`timescale 1ns / 1ps
// Package for the vertical bit-packing encoder: field widths, the column
// descriptor and result types, and the column width function.
// No dependencies.
package vbp_pkg;

	localparam int DGAP_W     = 32;
	localparam int COLW_W     = 6;
	localparam int CHUNK_W    = 64;
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 80;
	localparam int M_TUSER_W  = 2;
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PW    = 1;
	localparam int CMDQ_CW    = 2;

	// Result kind codes
	localparam logic KIND_CHUNK    = 1'b0;
	localparam logic KIND_SELECTOR = 1'b1;

	// Descriptor of one finished column, beside its lane data
	typedef struct packed {
		logic [COLW_W-1:0] width;
		logic              last;
	} col_meta_t;

	// One result item as the back end emits it
	typedef struct packed {
		logic               kind;
		logic [2:0]         lane_pair;
		logic [CHUNK_W-1:0] payload;
		logic [COLW_W-1:0]  width;
		logic               end_of_run;
		logic               end_of_list;
	} res_t;

	// Bit length of a column OR, at least 1; leading-zero search in five steps
	function automatic logic [COLW_W-1:0] col_bit_len(input logic [DGAP_W-1:0] v);
		logic [DGAP_W-1:0] x;
		logic [COLW_W-1:0] lz;
		x  = v;
		lz = '0;
		if ((x & 32'hffff0000) == '0) begin
			lz = lz + 6'd16;
			x  = x << 16;
		end
		if ((x & 32'hff000000) == '0) begin
			lz = lz + 6'd8;
			x  = x << 8;
		end
		if ((x & 32'hf0000000) == '0) begin
			lz = lz + 6'd4;
			x  = x << 4;
		end
		if ((x & 32'hc0000000) == '0) begin
			lz = lz + 6'd2;
			x  = x << 2;
		end
		if ((x & 32'h80000000) == '0) begin
			lz = lz + 6'd1;
		end
		if (v == '0) begin
			return 6'd1;
		end
		return 6'd32 - lz;
	endfunction

endpackage

// File: hdl/vertical_bitpack_encoder.sv
`timescale 1ns / 1ps
// Top level of the vertical bit-packing encoder: front end, command queue,
// back end and stream packing. Uses vbp_pkg, vbp_front, vbp_cmd_fifo, vbp_back.
//
//  channel  | dir | tdata                                   | tuser              | tlast
//  ---------+-----+-----------------------------------------+--------------------+-----------
//  s_axis   | in  | dgap_value                              | -                  | is_last
//  m_axis   | out | lane_pair, payload_data, sel_width      | out_kind, end_of_list | end_of_run
//
// One d-gap is taken per cycle while the command queue is not full. A column
// leaves the front end with its last item and costs the back end one selector
// result, plus (LANES+1)/2 chunk results per word flush; the back end emits one
// result per cycle unless the output stalls, so a column yields 1 to 1+2*((LANES+1)/2)
// results (17 at 16 lanes). Two columns wait in the queue; the front end stalls
// only when both slots are taken. An output register holds each result until
// m_axis_tready. Reset at once clears control state and the packed word, not data stores.
module vertical_bitpack_encoder import vbp_pkg::*; #(
	parameter int LANES     = 16,
	parameter int LANE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [31:0] dgap_value
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [2:0] lane_pair, [66:3] payload_data,
	                                              // [72:67] sel_width, [79:73] zero
	output logic [M_TUSER_W-1:0]  m_axis_tuser,   // [0] out_kind, [1] end_of_list
	output logic                  m_axis_tlast
);

	logic                         q_full;
	logic                         q_push;
	logic [LANES-1:0][DGAP_W-1:0] push_lanes;
	col_meta_t                    push_meta;
	logic                         q_valid;
	logic                         q_pop;
	logic [LANES-1:0][DGAP_W-1:0] head_lanes;
	col_meta_t                    head_meta;
	res_t                         res;

	vbp_front #(.LANES(LANES)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_value (s_axis_tdata[DGAP_W-1:0]),
		.in_last  (s_axis_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_lanes  (push_lanes),
		.q_meta   (push_meta)
	);

	vbp_cmd_fifo #(.LANES(LANES)) u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_lanes  (push_lanes),
		.wr_meta   (push_meta),
		.full      (q_full),
		.not_empty (q_valid),
		.pop       (q_pop),
		.rd_lanes  (head_lanes),
		.rd_meta   (head_meta)
	);

	vbp_back #(.LANES(LANES), .LANE_BITS(LANE_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_lanes   (head_lanes),
		.q_meta    (head_meta),
		.q_pop     (q_pop),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	// Pack result fields onto the stream
	assign m_axis_tdata = {7'd0, res.width, res.payload, res.lane_pair};
	assign m_axis_tuser = {res.end_of_list, res.kind};
	assign m_axis_tlast = res.end_of_run;

endmodule

// File: hdl/vbp_front.sv
`timescale 1ns / 1ps
// Front end: accepts d-gaps, collects one column and its OR, and hands each
// finished column with its width to the command queue. Uses vbp_pkg.
module vbp_front import vbp_pkg::*; #(
	parameter int LANES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [DGAP_W-1:0]              in_value,
	input  logic                           in_last,
	input  logic                           q_full,
	output logic                           q_push,
	output logic [LANES-1:0][DGAP_W-1:0]   q_lanes,
	output col_meta_t                      q_meta
);

	localparam int FW = $clog2(LANES);

	logic [FW-1:0]     fill_q;
	logic [DGAP_W-1:0] or_q;
	logic [DGAP_W-1:0] buf_q [LANES];
	logic              acc;
	logic              col_done;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;
	assign col_done = (fill_q == FW'(LANES - 1)) || in_last;
	assign q_push   = acc && col_done;

	// Build the column: stored lanes, the current item, zeros above it
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			if (i < int'(fill_q)) begin
				q_lanes[i] = buf_q[i];
			end else if (i == int'(fill_q)) begin
				q_lanes[i] = in_value;
			end else begin
				q_lanes[i] = '0;
			end
		end
		q_meta.width = col_bit_len(or_q | in_value);
		q_meta.last  = in_last;
	end

	// Advance the fill count and the running OR
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			or_q   <= '0;
		end else if (acc) begin
			if (col_done) begin
				fill_q <= '0;
				or_q   <= '0;
			end else begin
				fill_q <= fill_q + FW'(1);
				or_q   <= or_q | in_value;
			end
		end
	end

	// Store the item in its lane
	always_ff @(posedge clk) begin
		if (acc) begin
			buf_q[fill_q] <= in_value;
		end
	end

endmodule

// File: hdl/vbp_cmd_fifo.sv
`timescale 1ns / 1ps
// Command queue between front and back end: holds finished columns with
// their descriptors. Uses vbp_pkg.
module vbp_cmd_fifo import vbp_pkg::*; #(
	parameter int LANES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [LANES-1:0][DGAP_W-1:0]   wr_lanes,
	input  col_meta_t                      wr_meta,
	output logic                           full,
	output logic                           not_empty,
	input  logic                           pop,
	output logic [LANES-1:0][DGAP_W-1:0]   rd_lanes,
	output col_meta_t                      rd_meta
);

	logic [LANES-1:0][DGAP_W-1:0] lanes_q [CMDQ_DEPTH];
	col_meta_t                    meta_q  [CMDQ_DEPTH];
	logic [CMDQ_PW-1:0]           wr_ptr_q;
	logic [CMDQ_PW-1:0]           rd_ptr_q;
	logic [CMDQ_CW-1:0]           count_q;
	logic                         do_push;
	logic                         do_pop;

	assign full      = count_q == CMDQ_CW'(CMDQ_DEPTH);
	assign not_empty = count_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rd_lanes  = lanes_q[rd_ptr_q];
	assign rd_meta   = meta_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + CMDQ_PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + CMDQ_PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CMDQ_CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CMDQ_CW'(1);
			end
		end
	end

	// Store the entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			lanes_q[wr_ptr_q] <= wr_lanes;
			meta_q[wr_ptr_q]  <= wr_meta;
		end
	end

endmodule

// File: hdl/vbp_back.sv
`timescale 1ns / 1ps
// Back end: emits the selector of each queued column, packs the column into
// the lane word, flushes the word as lane-pair chunks. Uses vbp_pkg.
module vbp_back import vbp_pkg::*; #(
	parameter int LANES     = 16,
	parameter int LANE_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  logic [LANES-1:0][DGAP_W-1:0]   q_lanes,
	input  col_meta_t                      q_meta,
	output logic                           q_pop,
	output logic                           res_valid,
	input  logic                           res_ready,
	output res_t                           res
);

	localparam int NCHUNKS = (LANES + 1) / 2;
	localparam int CK_W    = (NCHUNKS > 1) ? $clog2(NCHUNKS) : 1;
	localparam int BU_W    = $clog2(LANE_BITS + 1);

	typedef enum logic [2:0] {
		PH_SEL = 3'b001,
		PH_OLD = 3'b010,
		PH_FIN = 3'b100
	} phase_t;

	phase_t                 ph_q;
	logic [CK_W-1:0]        ck_q;
	logic [BU_W-1:0]        bits_q;
	logic [LANE_BITS-1:0]   word_q [LANES];
	logic                   out_v_q;
	res_t                   out_q;

	logic                   adv;
	logic                   fire;
	logic [7:0]             sum;
	logic                   ovf;
	logic                   last_ck;
	logic [BU_W-1:0]        bits_sat;
	logic [BU_W-1:0]        bits_fresh;
	logic [LANE_BITS-1:0]   sh_lane    [LANES];
	logic [LANE_BITS-1:0]   fresh_lane [LANES];
	logic [CHUNK_W-1:0]     pair_w     [NCHUNKS];
	res_t                   emit;

	assign adv       = !out_v_q || res_ready;
	assign fire      = q_valid && adv;
	assign sum       = 8'(bits_q) + 8'(q_meta.width);
	assign ovf       = (bits_q != '0) && (sum > 8'(LANE_BITS));
	assign last_ck   = ck_q == CK_W'(NCHUNKS - 1);
	assign bits_sat  = (sum > 8'(LANE_BITS)) ? BU_W'(LANE_BITS) : BU_W'(sum);
	assign bits_fresh = (8'(q_meta.width) > 8'(LANE_BITS)) ? BU_W'(LANE_BITS)
	                                                       : BU_W'(q_meta.width);
	assign res_valid = out_v_q;
	assign res       = out_q;

	// Shift each lane of the column by the bits already used
	always_comb begin
		logic [63:0] t_sh;
		logic [63:0] t_fr;
		for (int i = 0; i < LANES; i++) begin
			t_sh          = 64'(q_lanes[i]) << bits_q;
			t_fr          = 64'(q_lanes[i]);
			sh_lane[i]    = t_sh[LANE_BITS-1:0];
			fresh_lane[i] = t_fr[LANE_BITS-1:0];
		end
	end

	// Pair up lanes: low 32 bits of each lane, missing upper lane as zero
	always_comb begin
		logic [63:0] lo;
		logic [63:0] hi;
		for (int k = 0; k < NCHUNKS; k++) begin
			lo = 64'(word_q[2*k]);
			hi = (2*k + 1 < LANES) ? 64'(word_q[(2*k + 1) % LANES]) : 64'd0;
			pair_w[k] = {hi[31:0], lo[31:0]};
		end
	end

	// Form the result of this phase and decide when the column is retired
	always_comb begin
		emit       = '0;
		q_pop      = 1'b0;
		case (ph_q)
			PH_SEL: begin
				emit.kind       = KIND_SELECTOR;
				emit.width      = q_meta.width;
				emit.end_of_run = !ovf && !q_meta.last;
				q_pop           = fire && !ovf && !q_meta.last;
			end
			PH_OLD: begin
				emit.kind       = KIND_CHUNK;
				emit.lane_pair  = 3'(ck_q);
				emit.payload    = pair_w[ck_q];
				emit.end_of_run = last_ck && !q_meta.last;
				q_pop           = fire && last_ck && !q_meta.last;
			end
			PH_FIN: begin
				emit.kind        = KIND_CHUNK;
				emit.lane_pair   = 3'(ck_q);
				emit.payload     = pair_w[ck_q];
				emit.end_of_run  = last_ck;
				emit.end_of_list = last_ck;
				q_pop            = fire && last_ck;
			end
			default: begin
				emit  = '0;
				q_pop = 1'b0;
			end
		endcase
	end

	// Sequence phases, pack and clear the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_SEL;
			ck_q   <= '0;
			bits_q <= '0;
			for (int i = 0; i < LANES; i++) begin
				word_q[i] <= '0;
			end
		end else if (fire) begin
			case (ph_q)
				PH_SEL: begin
					ck_q <= '0;
					if (ovf) begin
						ph_q <= PH_OLD;
					end else begin
						for (int i = 0; i < LANES; i++) begin
							word_q[i] <= word_q[i] | sh_lane[i];
						end
						bits_q <= bits_sat;
						if (q_meta.last) begin
							ph_q <= PH_FIN;
						end
					end
				end
				PH_OLD: begin
					if (last_ck) begin
						for (int i = 0; i < LANES; i++) begin
							word_q[i] <= fresh_lane[i];
						end
						bits_q <= bits_fresh;
						ck_q   <= '0;
						ph_q   <= q_meta.last ? PH_FIN : PH_SEL;
					end else begin
						ck_q <= ck_q + CK_W'(1);
					end
				end
				PH_FIN: begin
					if (last_ck) begin
						for (int i = 0; i < LANES; i++) begin
							word_q[i] <= '0;
						end
						bits_q <= '0;
						ck_q   <= '0;
						ph_q   <= PH_SEL;
					end else begin
						ck_q <= ck_q + CK_W'(1);
					end
				end
				default: begin
					ph_q <= PH_SEL;
				end
			endcase
		end
	end

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= emit;
		end
	end

endmodule

// File: hdl/vbp_checker.sv
`timescale 1ns / 1ps
// Port checker for the vertical bit-packing encoder, bound to the top level.
// Uses vbp_pkg.
module vbp_checker import vbp_pkg::*; #(
	parameter int LANES = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [S_TDATA_W-1:0]  s_axis_tdata,
	input logic                  s_axis_tlast,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [M_TDATA_W-1:0]  m_axis_tdata,
	input logic [M_TUSER_W-1:0]  m_axis_tuser,
	input logic                  m_axis_tlast
);

	localparam int NCHUNKS = (LANES + 1) / 2;
	localparam logic [2:0] LAST_PAIR = 3'(NCHUNKS - 1);

	// An offered input item holds until it is taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=>
			s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
		else $error("input changed while stalled");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// Selectors carry a width from 1 to 32 and no chunk fields
	a_selector: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] == KIND_SELECTOR |->
			m_axis_tdata[66:0] == '0 && !m_axis_tuser[1]
			&& m_axis_tdata[72:67] != 6'd0 && m_axis_tdata[72:67] <= 6'd32)
		else $error("malformed selector");

	// End of list only on the closing chunk of a word, which also ends the run
	a_end_of_list: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |->
			m_axis_tuser[0] == KIND_CHUNK && m_axis_tlast
			&& m_axis_tdata[2:0] == LAST_PAIR)
		else $error("end of list on wrong result");

	// No result is offered right out of reset
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("result valid after reset");

endmodule

bind vertical_bitpack_encoder vbp_checker #(.LANES(LANES)) u_vbp_checker (.*);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for vertical_bitpack_encoder: drives d-gap lists on the
// slave stream and checks every result on the master stream against a column predictor.
// Depends on vbp_pkg and vertical_bitpack_encoder.
module tb_top;
	import vbp_pkg::*;

	localparam int LANES       = 16;
	localparam int LANE_BITS   = 32;
	localparam int PAIRS       = (LANES + 1) / 2;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RAND_ITEMS  = 380;

	// Column predictor and queue of results still owed by the block
	class pack_scoreboard;
		res_t        owed_q[$];
		bit   [31:0] col_vals[LANES];
		int          col_fill;
		bit   [31:0] col_or;
		bit   [31:0] word_lanes[LANES];
		int          word_bits;
		int          errors;

		function int bit_length(bit [31:0] v);
			int n;
			n = 0;
			while (v != 0) begin
				n++;
				v = v >> 1;
			end
			return (n == 0) ? 1 : n;
		endfunction

		// Emit the packed word as lane-pair chunks, then clear it
		function void emit_word(bit list_end);
			res_t r;
			for (int k = 0; k < PAIRS; k++) begin
				r = '0;
				r.kind = KIND_CHUNK;
				r.lane_pair = k[2:0];
				r.payload[31:0] = word_lanes[2*k];
				if (2*k + 1 < LANES)
					r.payload[63:32] = word_lanes[2*k+1];
				r.end_of_list = list_end && (k == PAIRS - 1);
				owed_q.push_back(r);
			end
			for (int i = 0; i < LANES; i++)
				word_lanes[i] = '0;
			word_bits = 0;
		endfunction

		// Note one accepted d-gap and queue the results it causes
		function void note_input(bit [31:0] v, bit last);
			res_t r;
			int   n0;
			int   w;
			n0 = owed_q.size();
			if (col_fill < LANES) begin
				col_vals[col_fill] = v;
				col_fill++;
			end
			col_or |= v;
			if (col_fill >= LANES || last) begin
				w = bit_length(col_or);
				r = '0;
				r.kind = KIND_SELECTOR;
				r.width = w[COLW_W-1:0];
				owed_q.push_back(r);
				if (word_bits > 0 && word_bits + w > LANE_BITS)
					emit_word(1'b0);
				for (int i = 0; i < LANES; i++)
					word_lanes[i] |= 32'(64'(col_vals[i]) << word_bits);
				word_bits += w;
				if (word_bits > LANE_BITS)
					word_bits = LANE_BITS;
				for (int i = 0; i < LANES; i++)
					col_vals[i] = '0;
				col_fill = 0;
				col_or = '0;
				if (last)
					emit_word(1'b1);
			end
			// Mark the last result of this item
			if (owed_q.size() > n0) begin
				r = owed_q.pop_back();
				r.end_of_run = 1'b1;
				owed_q.push_back(r);
			end
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser,
				logic tlast);
			res_t got;
			res_t want;
			got.kind        = tuser[0];
			got.lane_pair   = tdata[2:0];
			got.payload     = tdata[66:3];
			got.width       = tdata[72:67];
			got.end_of_run  = tlast;
			got.end_of_list = tuser[1];
			if (owed_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: unexpected result kind=%0d pair=%0d data=%h width=%0d",
						got.kind, got.lane_pair, got.payload, got.width);
				return;
			end
			want = owed_q.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10) begin
					$display("ERROR: result mismatch at %0t", $time);
					$display("  exp kind=%0d pair=%0d data=%h width=%0d eor=%0d eol=%0d",
						want.kind, want.lane_pair, want.payload, want.width,
						want.end_of_run, want.end_of_list);
					$display("  got kind=%0d pair=%0d data=%h width=%0d eor=%0d eol=%0d",
						got.kind, got.lane_pair, got.payload, got.width,
						got.end_of_run, got.end_of_list);
				end
			end
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic                 s_axis_tlast = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [M_TUSER_W-1:0] m_axis_tuser;
	logic                 m_axis_tlast;

	logic                 idle_on = 1'b1;
	int                   cycle_count = 0;
	pack_scoreboard       sb;

	logic [31:0] stripes[4] = '{32'hffffffff, 32'haaaaaaaa, 32'h55555555, 32'h00000000};

	vertical_bitpack_encoder #(
		.LANES     (LANES),
		.LANE_BITS (LANE_BITS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// Abort on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Check accepted results and stall the output at random
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 24);
	end

	// Offer one item, idling at random first, and hold it until accepted
	task automatic send_item(input logic [31:0] v, input logic last);
		while (idle_on && $urandom_range(0, 99) < 24) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_input(v, last);
	endtask

	// Hold off the sender until every owed result has come
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Random d-gap no wider than the column cap, often of exactly its drawn width
	function automatic logic [31:0] rand_dgap(int cap);
		int          wv;
		logic [31:0] v;
		if (cap == 0 || $urandom_range(0, 4) == 0)
			return '0;
		wv = $urandom_range(1, cap);
		v  = $urandom >> (32 - wv);
		if ($urandom_range(0, 2) == 0)
			v |= 32'h1 << (wv - 1);
		return v;
	endfunction

	initial begin
		int item_count;
		int list_len;
		int cap;
		int pick;
		bit mid_drain_done;

		sb = new;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single zero list: minimum width, all-zero flush
		send_item(32'h0, 1'b1);
		// Full-width striped column fills the word
		for (int i = 0; i < LANES; i++)
			send_item(stripes[i % 4], 1'b0);
		// Wide partial last column overflows the full word
		send_item(32'h80000000, 1'b1);
		send_item(32'h7, 1'b1);
		send_item(32'h0000ffff, 1'b0);
		send_item(32'h00010000, 1'b1);
		wait_drained();

		// Random lists, each column with its own width cap
		item_count = 0;
		mid_drain_done = 1'b0;
		while (item_count < RAND_ITEMS) begin
			idle_on <= !(item_count >= 150 && item_count < 250);
			pick = $urandom_range(0, 9);
			if (pick < 2)
				list_len = LANES * $urandom_range(1, 4);
			else if (pick == 2)
				list_len = $urandom_range(49, 90);
			else
				list_len = $urandom_range(1, 40);
			for (int j = 0; j < list_len; j++) begin
				if (j % LANES == 0) begin
					pick = $urandom_range(0, 9);
					cap = (pick == 0) ? 0 : (pick == 1) ? 32 : $urandom_range(1, 31);
				end
				send_item(rand_dgap(cap), j == list_len - 1);
				item_count++;
			end
			if (!mid_drain_done && item_count >= 300) begin
				wait_drained();
				mid_drain_done = 1'b1;
			end
		end

		// Drain and let any stray result show up
		wait_drained();
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
